// File: hw/rtl/ack_retry_transaction_manager_top_macros.svh
// Assertion macros used by the checker file of the transaction manager.
`ifndef ACK_RETRY_TRANSACTION_MANAGER_TOP_MACROS_SVH
`define ACK_RETRY_TRANSACTION_MANAGER_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ARQTM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define ARQTM_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/arqtm_pkg.sv
// ----------------------------------------------------------------------------
// ARQ transaction manager package
// Types, codes and helpers shared by the front, queue and back modules.
// ----------------------------------------------------------------------------
package arqtm_pkg;

	// Command codes of an input word.
	typedef enum logic [1:0] {
		CMD_TX    = 2'd0,
		CMD_FB    = 2'd1,
		CMD_POLL  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Feedback message classes.
	localparam logic [1:0] CLS_ACK  = 2'd0;
	localparam logic [1:0] CLS_NACK = 2'd1;

	// Result status codes.
	localparam logic [3:0] ST_OK            = 4'd0;
	localparam logic [3:0] ST_BUSY          = 4'd1;
	localparam logic [3:0] ST_TX_SEQ_MISM   = 4'd2;
	localparam logic [3:0] ST_NOT_WAITING   = 4'd3;
	localparam logic [3:0] ST_BAD_FRAME     = 4'd4;
	localparam logic [3:0] ST_FB_SEQ_MISM   = 4'd5;
	localparam logic [3:0] ST_NACK_EXHAUST  = 4'd6;
	localparam logic [3:0] ST_COMPLETED     = 4'd7;
	localparam logic [3:0] ST_RETRY_NACK    = 4'd8;
	localparam logic [3:0] ST_RETRY_TIMEOUT = 4'd9;
	localparam logic [3:0] ST_TIMEOUT_FAIL  = 4'd10;

	// Transaction state codes as shown on the result word.
	localparam logic [2:0] TXN_IDLE  = 3'd0;
	localparam logic [2:0] TXN_WAIT  = 3'd1;
	localparam logic [2:0] TXN_RETRY = 3'd2;
	localparam logic [2:0] TXN_DONE  = 3'd3;
	localparam logic [2:0] TXN_FAIL  = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_ACK_TIMEOUT = 1'b0;
	localparam logic CFG_RETRY_LIMIT = 1'b1;

	// Configuration defaults, also used when zero is written.
	localparam logic [31:0] ACK_TIMEOUT_DEFAULT = 32'd20000;
	localparam logic [7:0]  RETRY_LIMIT_DEFAULT = 8'd1;

	// Attempt counter saturation value.
	localparam logic [8:0] ATTEMPT_MAX = 9'd511;

	// Depth of the queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Transaction phase, one-hot.
	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_WAIT  = 5'b00010,
		PH_RETRY = 5'b00100,
		PH_DONE  = 5'b01000,
		PH_FAIL  = 5'b10000
	} phase_t;

	// Classified word travelling from the front to the back.
	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] tx_seq;
		logic [63:0] now_time;
		logic        fb_bad;
		logic        fb_nack;
		logic [15:0] fb_seq;
	} entry_t;

	// Result word held in the output register.
	typedef struct packed {
		logic [3:0] status;
		logic       retry_due;
		logic       failed;
		logic [2:0] txn_state;
	} result_t;

	// Maps the one-hot phase to its numeric state code.
	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		unique case (ph)
			PH_IDLE:  code = TXN_IDLE;
			PH_WAIT:  code = TXN_WAIT;
			PH_RETRY: code = TXN_RETRY;
			PH_DONE:  code = TXN_DONE;
			PH_FAIL:  code = TXN_FAIL;
			default:  code = TXN_IDLE;
		endcase
		return code;
	endfunction

endpackage

// File: hw/rtl/arqtm_front.sv
// ----------------------------------------------------------------------------
// ARQ transaction manager front
// Decodes the command and checks the feedback frame before queueing.
// ----------------------------------------------------------------------------
module arqtm_front #(
	parameter int ACK_PAYLOAD_LEN = 3
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	input  logic [15:0]       tx_seq,
	input  logic [63:0]       now_time,
	input  logic [1:0]        fb_msg_class,
	input  logic [15:0]       fb_payload_len,
	input  logic [7:0]        fb_seq_low,
	input  logic [7:0]        fb_seq_high,
	output logic              push,
	output arqtm_pkg::entry_t push_entry,
	input  logic              q_full
);

	localparam logic [15:0] MinLen = 16'(ACK_PAYLOAD_LEN);

	// A word is taken whenever the queue has a free slot.
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// Frame checks: unknown class or short payload is a bad frame.
	always_comb begin
		push_entry.cmd      = arqtm_pkg::cmd_t'(command);
		push_entry.tx_seq   = tx_seq;
		push_entry.now_time = now_time;
		push_entry.fb_bad   = (fb_msg_class != arqtm_pkg::CLS_ACK &&
			fb_msg_class != arqtm_pkg::CLS_NACK) || (fb_payload_len < MinLen);
		push_entry.fb_nack  = (fb_msg_class == arqtm_pkg::CLS_NACK);
		push_entry.fb_seq   = {fb_seq_high, fb_seq_low};
	end

endmodule

// File: hw/rtl/arqtm_queue.sv
// ----------------------------------------------------------------------------
// ARQ transaction manager queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module arqtm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  arqtm_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output arqtm_pkg::entry_t head_entry
);

	arqtm_pkg::entry_t                 mem_q [arqtm_pkg::QDEPTH];
	logic [arqtm_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [arqtm_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [arqtm_pkg::QCNT_W-1:0]      count_q;

	localparam logic [arqtm_pkg::QPTR_W-1:0] PtrLast = arqtm_pkg::QPTR_W'(arqtm_pkg::QDEPTH - 1);
	localparam logic [arqtm_pkg::QCNT_W-1:0] CntFull = arqtm_pkg::QCNT_W'(arqtm_pkg::QDEPTH);

	assign full       = (count_q == CntFull);
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/arqtm_back.sv
// ----------------------------------------------------------------------------
// ARQ transaction manager back
// Runs the transaction state machine and holds the result register.
// ----------------------------------------------------------------------------
module arqtm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_wdata,
	input  logic              head_valid,
	input  arqtm_pkg::entry_t head_entry,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output arqtm_pkg::result_t result
);

	logic [31:0]        ack_timeout_q;
	logic [7:0]         retry_limit_q;
	arqtm_pkg::phase_t  phase_q, phase_d;
	logic [15:0]        pending_seq_q, pending_seq_d;
	logic [8:0]         attempt_q, attempt_d;
	logic [63:0]        last_send_q, last_send_d;
	logic [63:0]        elapsed;
	logic               timed_out;
	logic               retries_left;
	arqtm_pkg::result_t res_d;
	arqtm_pkg::result_t res_q;
	logic               out_valid_q;

	// A word is processed when the result register is free or being drained.
	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = res_q;

	// Configuration registers; a written zero selects the default.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= arqtm_pkg::ACK_TIMEOUT_DEFAULT;
			retry_limit_q <= arqtm_pkg::RETRY_LIMIT_DEFAULT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				arqtm_pkg::CFG_ACK_TIMEOUT: begin
					ack_timeout_q <= (cfg_wdata == '0) ? arqtm_pkg::ACK_TIMEOUT_DEFAULT
						: cfg_wdata;
				end
				arqtm_pkg::CFG_RETRY_LIMIT: begin
					retry_limit_q <= (cfg_wdata[7:0] == '0) ? arqtm_pkg::RETRY_LIMIT_DEFAULT
						: cfg_wdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Timeout test with wrapping 64-bit subtraction.
	assign elapsed      = head_entry.now_time - last_send_q;
	assign timed_out    = (elapsed >= {32'd0, ack_timeout_q});
	assign retries_left = (attempt_q <= {1'b0, retry_limit_q});

	// Next transaction state and result for the word at the queue head.
	always_comb begin
		phase_d         = phase_q;
		pending_seq_d   = pending_seq_q;
		attempt_d       = attempt_q;
		last_send_d     = last_send_q;
		res_d.status    = arqtm_pkg::ST_OK;
		res_d.retry_due = 1'b0;
		res_d.failed    = 1'b0;
		unique case (head_entry.cmd)
			arqtm_pkg::CMD_TX: begin
				if (phase_q == arqtm_pkg::PH_WAIT) begin
					res_d.status = arqtm_pkg::ST_BUSY;
				end else if (phase_q == arqtm_pkg::PH_RETRY &&
					head_entry.tx_seq != pending_seq_q) begin
					res_d.status = arqtm_pkg::ST_TX_SEQ_MISM;
				end else begin
					if (phase_q == arqtm_pkg::PH_RETRY) begin
						if (attempt_q != arqtm_pkg::ATTEMPT_MAX) begin
							attempt_d = attempt_q + 9'd1;
						end
					end else begin
						pending_seq_d = head_entry.tx_seq;
						attempt_d     = 9'd1;
					end
					last_send_d = head_entry.now_time;
					phase_d     = arqtm_pkg::PH_WAIT;
				end
			end
			arqtm_pkg::CMD_FB: begin
				if (phase_q != arqtm_pkg::PH_WAIT) begin
					res_d.status = arqtm_pkg::ST_NOT_WAITING;
				end else if (head_entry.fb_bad) begin
					res_d.status = arqtm_pkg::ST_BAD_FRAME;
				end else if (head_entry.fb_seq != pending_seq_q) begin
					res_d.status = arqtm_pkg::ST_FB_SEQ_MISM;
				end else if (!head_entry.fb_nack) begin
					phase_d      = arqtm_pkg::PH_DONE;
					res_d.status = arqtm_pkg::ST_COMPLETED;
				end else if (!retries_left) begin
					phase_d      = arqtm_pkg::PH_FAIL;
					res_d.status = arqtm_pkg::ST_NACK_EXHAUST;
				end else begin
					phase_d      = arqtm_pkg::PH_RETRY;
					res_d.status = arqtm_pkg::ST_RETRY_NACK;
				end
			end
			arqtm_pkg::CMD_POLL: begin
				if (phase_q == arqtm_pkg::PH_WAIT && timed_out) begin
					if (retries_left) begin
						phase_d         = arqtm_pkg::PH_RETRY;
						res_d.retry_due = 1'b1;
						res_d.status    = arqtm_pkg::ST_RETRY_TIMEOUT;
					end else begin
						phase_d      = arqtm_pkg::PH_FAIL;
						res_d.failed = 1'b1;
						res_d.status = arqtm_pkg::ST_TIMEOUT_FAIL;
					end
				end
			end
			arqtm_pkg::CMD_CLEAR: begin
				phase_d       = arqtm_pkg::PH_IDLE;
				pending_seq_d = '0;
				attempt_d     = '0;
				last_send_d   = '0;
			end
			default: begin
			end
		endcase
		res_d.txn_state = arqtm_pkg::phase_code(phase_d);
	end

	// Transaction state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= arqtm_pkg::PH_IDLE;
			pending_seq_q <= '0;
			attempt_q     <= '0;
			last_send_q   <= '0;
		end else if (pop) begin
			phase_q       <= phase_d;
			pending_seq_q <= pending_seq_d;
			attempt_q     <= attempt_d;
			last_send_q   <= last_send_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

// File: hw/rtl/ack_retry_transaction_manager_top.sv
// A word accepted on the input is written into the queue; the back registers its result word when it pops the word.
// Throughput: one word per cycle while out_ready drains the result register; the back state
// machine with its 64-bit timeout subtraction settles one word in each such cycle, and a two-word queue decouples it.
// Reset (arst_n low, asynchronous) empties the queue and the result register,
// returns the transaction to idle and restores the configuration defaults.
// ----------------------------------------------------------------------------
// ARQ transaction manager top level
// Stop-and-wait transaction tracker with a retry limit for one pending frame.
// ----------------------------------------------------------------------------
module ack_retry_transaction_manager_top #(
	parameter int ACK_PAYLOAD_LEN = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] tx_seq,
	input  logic [63:0] now_time,
	input  logic [1:0]  fb_msg_class,
	input  logic [15:0] fb_payload_len,
	input  logic [7:0]  fb_seq_low,
	input  logic [7:0]  fb_seq_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic        retry_due,
	output logic        failed,
	output logic [2:0]  txn_state
);

	logic               push;
	logic               q_full;
	logic               pop;
	logic               head_valid;
	arqtm_pkg::entry_t  push_entry;
	arqtm_pkg::entry_t  head_entry;
	arqtm_pkg::result_t result;

	// Front: decode and frame checks.
	arqtm_front #(
		.ACK_PAYLOAD_LEN(ACK_PAYLOAD_LEN)
	) u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.tx_seq         (tx_seq),
		.now_time       (now_time),
		.fb_msg_class   (fb_msg_class),
		.fb_payload_len (fb_payload_len),
		.fb_seq_low     (fb_seq_low),
		.fb_seq_high    (fb_seq_high),
		.push           (push),
		.push_entry     (push_entry),
		.q_full         (q_full)
	);

	// Queue between the two halves.
	arqtm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// Back: transaction state machine and result register.
	arqtm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result)
	);

	assign status    = result.status;
	assign retry_due = result.retry_due;
	assign failed    = result.failed;
	assign txn_state = result.txn_state;

endmodule

// File: hw/rtl/arqtm_checker.sv
// ----------------------------------------------------------------------------
// ARQ transaction manager checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ack_retry_transaction_manager_top_macros.svh"

module arqtm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] status,
	input logic       retry_due,
	input logic       failed,
	input logic [2:0] txn_state
);

	// A stalled result word keeps its contents.
	`ARQTM_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(txn_state)), "result word changed while stalled")

	// A timeout retry leaves the transaction in retry ready.
	`ARQTM_ASSERT(a_retry_flag, clk, arst_n, (out_valid && retry_due) |-> (status == arqtm_pkg::ST_RETRY_TIMEOUT && txn_state == arqtm_pkg::TXN_RETRY && !failed), "retry flag inconsistent with status or state")

	// A timeout failure leaves the transaction failed.
	`ARQTM_ASSERT(a_fail_flag, clk, arst_n, (out_valid && failed) |-> (status == arqtm_pkg::ST_TIMEOUT_FAIL && txn_state == arqtm_pkg::TXN_FAIL), "fail flag inconsistent with status or state")

	// Completion always shows the completed state.
	`ARQTM_ASSERT(a_done_state, clk, arst_n, (out_valid && status == arqtm_pkg::ST_COMPLETED) |-> (txn_state == arqtm_pkg::TXN_DONE), "completed status without completed state")

	// No result word is shown while reset is held.
	`ARQTM_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid, "result word valid during reset")

endmodule

bind ack_retry_transaction_manager_top arqtm_checker u_checker (.*);

// File: dv/tb_ack_retry_transaction_manager_top.sv
// ----------------------------------------------------------------------------
// Testbench for the ARQ transaction manager
// Drives command words through the valid/ready input, keeps a cycle-free
// prediction of the stop-and-wait tracker and checks every result word in
// order, with random idling on both sides and several register settings.
// ----------------------------------------------------------------------------
module tb_ack_retry_transaction_manager_top;
	import arqtm_pkg::*;

	localparam int ACK_LEN     = 3;
	localparam int STALL_LIMIT = 2000;

	// One command word as offered on the input channel.
	typedef struct {
		cmd_t        cmd;
		logic [15:0] tx_seq;
		logic [63:0] now_time;
		logic [1:0]  cls;
		logic [15:0] plen;
		logic [7:0]  seq_lo;
		logic [7:0]  seq_hi;
	} cmd_word_t;

	// Tracks the transaction as the block should and holds the result words
	// still to come back.
	class arq_scoreboard;
		logic [2:0]  cur_state;
		logic [15:0] held_seq;
		logic [8:0]  tries;
		logic [63:0] sent_time;
		logic [31:0] timeout_us;
		logic [7:0]  max_tries;
		result_t     awaited[$];
		int          errors;

		function new();
			timeout_us = ACK_TIMEOUT_DEFAULT;
			max_tries  = RETRY_LIMIT_DEFAULT;
			errors     = 0;
			clear_txn();
		endfunction

		function void clear_txn();
			cur_state = TXN_IDLE;
			held_seq  = '0;
			tries     = '0;
			sent_time = '0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// A written zero falls back to the default of that register.
		function void write_reg(logic idx, logic [31:0] data);
			if (idx == CFG_ACK_TIMEOUT) begin
				timeout_us = (data == '0) ? ACK_TIMEOUT_DEFAULT : data;
			end else begin
				max_tries = (data[7:0] == '0) ? RETRY_LIMIT_DEFAULT : data[7:0];
			end
		endfunction

		// Works out the result word of one accepted command word.
		function void note_word(cmd_t cmd, logic [15:0] seq, logic [63:0] now,
				logic [1:0] cls, logic [15:0] plen, logic [15:0] fseq);
			result_t r;
			r = '0;
			r.status = ST_OK;
			case (cmd)
				CMD_TX: begin
					if (cur_state == TXN_WAIT) begin
						r.status = ST_BUSY;
					end else if (cur_state == TXN_RETRY && seq != held_seq) begin
						r.status = ST_TX_SEQ_MISM;
					end else begin
						if (cur_state == TXN_RETRY) begin
							if (tries != ATTEMPT_MAX)
								tries = tries + 9'd1;
						end else begin
							held_seq = seq;
							tries    = 9'd1;
						end
						sent_time = now;
						cur_state = TXN_WAIT;
					end
				end
				CMD_FB: begin
					if (cur_state != TXN_WAIT) begin
						r.status = ST_NOT_WAITING;
					end else if ((cls != CLS_ACK && cls != CLS_NACK) || plen < ACK_LEN) begin
						r.status = ST_BAD_FRAME;
					end else if (fseq != held_seq) begin
						r.status = ST_FB_SEQ_MISM;
					end else if (cls == CLS_ACK) begin
						cur_state = TXN_DONE;
						r.status  = ST_COMPLETED;
					end else if (tries > {1'b0, max_tries}) begin
						cur_state = TXN_FAIL;
						r.status  = ST_NACK_EXHAUST;
					end else begin
						cur_state = TXN_RETRY;
						r.status  = ST_RETRY_NACK;
					end
				end
				CMD_POLL: begin
					// Elapsed time wraps modulo 2**64.
					if (cur_state == TXN_WAIT && (now - sent_time) >= {32'd0, timeout_us}) begin
						if (tries <= {1'b0, max_tries}) begin
							cur_state   = TXN_RETRY;
							r.retry_due = 1'b1;
							r.status    = ST_RETRY_TIMEOUT;
						end else begin
							cur_state = TXN_FAIL;
							r.failed  = 1'b1;
							r.status  = ST_TIMEOUT_FAIL;
						end
					end
				end
				default: begin
					clear_txn();
				end
			endcase
			r.txn_state = cur_state;
			awaited.push_back(r);
		endfunction

		// Compares one returned result word with the oldest one awaited.
		function void check_result(result_t got);
			result_t e;
			if (awaited.size() == 0) begin
				$display("%0t: result word with none awaited, status %0d state %0d",
					$time, got.status, got.txn_state);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d, got %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.retry_due !== e.retry_due) begin
				$display("%0t: retry_due expected %0b, got %0b",
					$time, e.retry_due, got.retry_due);
				errors++;
			end
			if (got.failed !== e.failed) begin
				$display("%0t: failed expected %0b, got %0b", $time, e.failed, got.failed);
				errors++;
			end
			if (got.txn_state !== e.txn_state) begin
				$display("%0t: txn_state expected %0d, got %0d",
					$time, e.txn_state, got.txn_state);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [15:0] tx_seq;
	logic [63:0] now_time;
	logic [1:0]  fb_msg_class;
	logic [15:0] fb_payload_len;
	logic [7:0]  fb_seq_low;
	logic [7:0]  fb_seq_high;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  status;
	logic        retry_due;
	logic        failed;
	logic [2:0]  txn_state;

	arq_scoreboard sb;

	// Stimulus state: idling control, the receiver hold-off and the time base.
	bit          calm;
	int          rx_hold;
	int          sent_count;
	logic [63:0] clock_us;
	logic [63:0] sent_at;
	logic [15:0] cur_seq;
	logic [31:0] eff_timeout;

	ack_retry_transaction_manager_top #(
		.ACK_PAYLOAD_LEN(ACK_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.tx_seq(tx_seq),
		.now_time(now_time),
		.fb_msg_class(fb_msg_class),
		.fb_payload_len(fb_payload_len),
		.fb_seq_low(fb_seq_low),
		.fb_seq_high(fb_seq_high),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.retry_due(retry_due),
		.failed(failed),
		.txn_state(txn_state)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure, or a long counted hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold = rx_hold - 1;
			end else begin
				out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
			end
		end
	end

	// Samples both handshakes and register writes at each rising edge.
	always @(posedge clk) begin : monitor
		result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.status    = status;
				got.retry_due = retry_due;
				got.failed    = failed;
				got.txn_state = txn_state;
				sb.check_result(got);
			end
			if (cfg_wr_en)
				sb.write_reg(cfg_index, cfg_wdata);
			if (in_valid && in_ready)
				sb.note_word(cmd_t'(command), tx_seq, now_time, fb_msg_class,
					fb_payload_len, {fb_seq_high, fb_seq_low});
		end
	end

	// Ends the run if nothing moves on either channel for too long.
	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !arst_n)
				stall = 0;
			else
				stall++;
		end
		$display("FAILURE");
		$finish;
	end

	// Offers one word after an optional random gap and waits for acceptance.
	task automatic send_word(input cmd_word_t w);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= w.cmd;
		tx_seq         <= w.tx_seq;
		now_time       <= w.now_time;
		fb_msg_class   <= w.cls;
		fb_payload_len <= w.plen;
		fb_seq_low     <= w.seq_lo;
		fb_seq_high    <= w.seq_hi;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic issue(input cmd_word_t w);
		send_word(w);
		if (w.cmd == CMD_TX)
			sent_at = w.now_time;
		sent_count++;
	endtask

	// Drops valid and waits until every awaited result word is back.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (3) @(posedge clk);
	endtask

	// Writes both registers while the block is idle.
	task automatic load_regs(input logic [31:0] tmo, input logic [31:0] lim_word);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_wdata <= lim_word;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		eff_timeout = (tmo == '0) ? ACK_TIMEOUT_DEFAULT : tmo;
	endtask

	function automatic cmd_word_t dw(cmd_t c, logic [15:0] seq, logic [63:0] now,
			logic [1:0] cls, logic [15:0] plen, logic [15:0] fseq);
		cmd_word_t w;
		w.cmd      = c;
		w.tx_seq   = seq;
		w.now_time = now;
		w.cls      = cls;
		w.plen     = plen;
		w.seq_lo   = fseq[7:0];
		w.seq_hi   = fseq[15:8];
		return w;
	endfunction

	// Fully random word; the fields a command ignores keep random content.
	function automatic cmd_word_t rand_word();
		cmd_word_t w;
		w.cmd      = cmd_t'($urandom_range(3));
		w.tx_seq   = 16'($urandom);
		w.now_time = {$urandom, $urandom};
		w.cls      = 2'($urandom);
		w.plen     = 16'($urandom);
		w.seq_lo   = 8'($urandom);
		w.seq_hi   = 8'($urandom);
		return w;
	endfunction

	// Moves the time base on, now and then to just below the wrap point.
	function automatic void advance_clock();
		if ($urandom_range(49) == 0)
			clock_us = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3000);
		else
			clock_us = clock_us + $urandom_range(60);
	endfunction

	// Feedback frame with a valid length and the given class and sequence.
	function automatic cmd_word_t good_frame(logic [1:0] cls, logic [15:0] seq);
		cmd_word_t w;
		w = rand_word();
		w.cmd  = CMD_FB;
		w.cls  = cls;
		w.plen = ($urandom_range(1) == 0) ? 16'(ACK_LEN) : 16'($urandom_range(ACK_LEN, 65535));
		{w.seq_hi, w.seq_lo} = seq;
		return w;
	endfunction

	// Poll that lands either just at or past the timeout, or short of it.
	function automatic cmd_word_t poll_word(bit late);
		cmd_word_t w;
		w = rand_word();
		w.cmd = CMD_POLL;
		if (late)
			w.now_time = sent_at + eff_timeout + $urandom_range(2);
		else
			w.now_time = sent_at + ($urandom % eff_timeout);
		return w;
	endfunction

	// One transaction: a transmit followed by feedback, polls and resends.
	task automatic txn_sequence();
		cmd_word_t w;
		int steps;
		advance_clock();
		cur_seq = 16'($urandom);
		w = rand_word();
		w.cmd      = CMD_TX;
		w.tx_seq   = cur_seq;
		w.now_time = clock_us;
		issue(w);
		steps = $urandom_range(1, 8);
		repeat (steps) begin
			advance_clock();
			case ($urandom_range(9))
				0, 1: w = good_frame(CLS_ACK, cur_seq);
				2, 3: w = good_frame(CLS_NACK, cur_seq);
				4: begin
					// Broken frame: other class, short length or wrong sequence.
					w = good_frame(2'($urandom_range(1)), cur_seq);
					case ($urandom_range(2))
						0: w.cls = 2'($urandom_range(2, 3));
						1: w.plen = 16'($urandom_range(ACK_LEN - 1));
						default: {w.seq_hi, w.seq_lo} = cur_seq ^ (16'd1 << $urandom_range(15));
					endcase
				end
				5: w = poll_word(1'b0);
				6, 7: w = poll_word(1'b1);
				8: begin
					w = rand_word();
					w.cmd      = CMD_TX;
					w.tx_seq   = cur_seq;
					w.now_time = clock_us;
				end
				default: begin
					w = rand_word();
					w.cmd      = ($urandom_range(2) == 0) ? CMD_CLEAR : CMD_TX;
					w.now_time = clock_us;
				end
			endcase
			issue(w);
		end
	endtask

	// Mostly well-formed transactions, with bursts of random words between.
	task automatic run_mix(input int n);
		int start;
		start = sent_count;
		while (sent_count - start < n) begin
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) issue(rand_word());
			else
				txn_sequence();
		end
	endtask

	// Keeps one transaction retrying until the attempt count runs past the limit.
	task automatic retry_chain(input int rounds);
		cmd_word_t w;
		cur_seq = 16'($urandom);
		advance_clock();
		issue(dw(CMD_TX, cur_seq, clock_us, 2'd0, 16'd0, 16'd0));
		repeat (rounds) begin
			advance_clock();
			if ($urandom_range(3) == 0)
				w = poll_word(1'b1);
			else
				w = good_frame(CLS_NACK, cur_seq);
			issue(w);
			advance_clock();
			w = rand_word();
			w.cmd      = CMD_TX;
			w.tx_seq   = cur_seq;
			w.now_time = clock_us;
			issue(w);
		end
	endtask

	// Main sequence: reset, directed words, then random phases per setting.
	initial begin
		sb             = new();
		calm           = 1'b0;
		rx_hold        = 0;
		sent_count     = 0;
		clock_us       = {$urandom, $urandom};
		sent_at        = '0;
		cur_seq        = '0;
		eff_timeout    = ACK_TIMEOUT_DEFAULT;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = CFG_ACK_TIMEOUT;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		command        = CMD_TX;
		tx_seq         = '0;
		now_time       = '0;
		fb_msg_class   = CLS_ACK;
		fb_payload_len = '0;
		fb_seq_low     = '0;
		fb_seq_high    = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset settings: timeout 20000, one retry.
		issue(dw(CMD_FB, 16'h0000, 64'd0, CLS_ACK, 16'd3, 16'h0000));
		issue(dw(CMD_POLL, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_TX, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF0, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_TX, 16'hFFFF, 64'd0, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_FB, 16'h0000, 64'd0, 2'd2, 16'd3, 16'hFFFF));
		issue(dw(CMD_FB, 16'h0000, 64'd0, 2'd3, 16'd0, 16'hFFFF));
		issue(dw(CMD_FB, 16'h0000, 64'd0, CLS_ACK, 16'd2, 16'hFFFF));
		issue(dw(CMD_FB, 16'h0000, 64'd0, CLS_ACK, 16'd3, 16'h00FF));
		// Polls across the 64-bit wrap: one short of the timeout, then at it.
		issue(dw(CMD_POLL, 16'h0000, 64'hFFFF_FFFF_FFFF_FFF0 + 64'd19999, CLS_ACK,
			16'd0, 16'h0000));
		issue(dw(CMD_POLL, 16'h0000, 64'hFFFF_FFFF_FFFF_FFF0 + 64'd20000, CLS_ACK,
			16'd0, 16'h0000));
		issue(dw(CMD_TX, 16'h0000, 64'd1, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_TX, 16'hFFFF, 64'd5, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_FB, 16'h0000, 64'd0, CLS_NACK, 16'd3, 16'hFFFF));
		issue(dw(CMD_FB, 16'h0000, 64'd0, CLS_ACK, 16'd3, 16'hFFFF));
		issue(dw(CMD_POLL, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_TX, 16'h1234, 64'd0, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_FB, 16'h0000, 64'd0, CLS_NACK, 16'hFFFF, 16'h1234));
		issue(dw(CMD_TX, 16'h1234, 64'd100, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_POLL, 16'h0000, 64'd20100, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_TX, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_FB, 16'h0000, 64'd0, CLS_ACK, 16'd3, 16'h0000));
		issue(dw(CMD_TX, 16'h8001, 64'd7, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_CLEAR, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 16'hFFFF, 16'hFFFF));
		issue(dw(CMD_TX, 16'hABCD, 64'hFFFF_FFFF_FFFF_FFFF, CLS_ACK, 16'd0, 16'h0000));
		issue(dw(CMD_CLEAR, 16'h0000, 64'd0, CLS_ACK, 16'd0, 16'h0000));

		// Zero written to both registers falls back to the defaults.
		load_regs(32'd0, {8'($urandom), 16'($urandom), 8'd0});
		run_mix(60);

		// Shortest timeout, a few retries, and no idling on either side.
		load_regs(32'd1, {24'($urandom), 8'd3});
		calm = 1'b1;
		run_mix(60);
		calm = 1'b0;

		// Longest timeout; the receiver holds off long enough to fill the block.
		load_regs(32'hFFFF_FFFF, {24'($urandom), 8'd2});
		rx_hold = 300;
		run_mix(60);

		// Largest retry limit: one transaction runs through every attempt.
		load_regs($urandom_range(50, 500), {24'($urandom), 8'd255});
		retry_chain(258);
		run_mix(20);

		// Random settings.
		load_regs($urandom, $urandom);
		run_mix(60);

		settle();
		if (sb.pending() != 0) begin
			$display("%0t: %0d result words never arrived", $time, sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
